// ----- rtl/ckset_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckset_pkg
// Shared types, codes and defaults for the compacting key set.
// ----------------------------------------------------------------------------
package ckset_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int OPCODE_W = 2;
  localparam int KEY_IN_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [KEY_IN_W-1:0] key;
  } ckset_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } ckset_rsp_t;

  // broadcast to every cell for one request
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } ckset_ctl_t;

endpackage : ckset_pkg
`default_nettype wire

// ----- rtl/compacting_key_set_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A word taken into the input holding register has its result registered
// in the result register when the result side is free.
// Throughput: one request per cycle if rsp_stall is low; every request settles
// in a single pass through the cell row (compare, hit chain, shift or append).
// Reset: count and both valid flags clear; stored keys are not cleared.
// ----------------------------------------------------------------------------
// compacting_key_set_unit
// Packed list of distinct nonzero keys built as a row of cells. Query,
// insert (append), delete (with compaction) and clear; one result per word.
// ----------------------------------------------------------------------------
module compacting_key_set_unit #(
  parameter int CAPACITY  = ckset_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = ckset_pkg::KEY_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    req_valid,
  output logic                   req_stall,
  input  ckset_pkg::ckset_req_t  req,
  output logic                   rsp_valid,
  input  wire                    rsp_stall,
  output ckset_pkg::ckset_rsp_t  rsp
);
  import ckset_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // input holding register
  logic        hold_valid;
  ckset_req_t  hold;
  logic        advance;

  // key as seen by the cells (low KEY_WIDTH bits, or zero-extended)
  logic [KEY_WIDTH-1:0] k;

  // entry count
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // cell row
  logic [KEY_WIDTH-1:0] keys [CAPACITY];
  logic [CAPACITY:0]    seen;
  logic                 hit;
  logic                 key_zero;
  ckset_ctl_t           ctl;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   cnt_field;

  // a request executes when the result register is free or being drained
  assign advance   = hold_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold <= req;
    end
  end

  generate
    if (KEY_WIDTH <= KEY_IN_W) begin : g_key_narrow
      assign k = hold.key[KEY_WIDTH-1:0];
    end else begin : g_key_wide
      assign k = {{(KEY_WIDTH-KEY_IN_W){1'b0}}, hold.key};
    end
  endgenerate

  assign key_zero = (k == '0);

  // hit chain runs from slot 0 upward; its tail is "key held anywhere"
  assign seen[0] = 1'b0;
  assign hit     = seen[CAPACITY];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [KEY_WIDTH-1:0] nbr;
      if (gi < CAPACITY - 1) begin : g_mid
        assign nbr = keys[gi+1];
      end else begin : g_last
        // last slot falls out of the live range on delete
        assign nbr = keys[gi];
      end
      ckset_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W),
        .IDX       (gi)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .k        (k),
        .cnt      (cnt),
        .next_key (nbr),
        .seen_in  (seen[gi]),
        .seen_out (seen[gi+1]),
        .key_out  (keys[gi])
      );
    end
  endgenerate

  // request decode; zero key is rejected for all but clear,
  // duplicate wins over full on insert
  always_comb begin
    ctl      = '0;
    status   = ST_OK;
    cnt_next = cnt;
    case (hold.opcode)
      OP_QUERY: begin
        status = (key_zero || !hit) ? ST_MISS : ST_OK;
      end
      OP_INSERT: begin
        if (key_zero || hit) begin
          status = ST_MISS;
        end else if (cnt == CNT_W'(CAPACITY)) begin
          status = ST_FULL;
        end else begin
          ctl.ins_en = advance;
          cnt_next   = cnt + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (key_zero || !hit) begin
          status = ST_MISS;
        end else begin
          ctl.del_en = advance;
          cnt_next   = cnt - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (advance) begin
      cnt <= cnt_next;
    end
  end

  // count field is the updated count, cut to its low bits or zero-extended
  generate
    if (CNT_W >= COUNT_W) begin : g_cnt_trunc
      assign cnt_field = cnt_next[COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign cnt_field = {{(COUNT_W-CNT_W){1'b0}}, cnt_next};
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status <= status;
      rsp.count  <= cnt_field;
    end
  end

endmodule : compacting_key_set_unit
`default_nettype wire

// ----- rtl/ckset_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckset_cell
// One slot of the key list: compare, append at tail, shift from the neighbor.
// ----------------------------------------------------------------------------
module ckset_cell #(
  parameter int KEY_WIDTH = ckset_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  wire                    clk,
  input  ckset_pkg::ckset_ctl_t  ctl,
  input  wire  [KEY_WIDTH-1:0]   k,
  input  wire  [CNT_W-1:0]       cnt,
  input  wire  [KEY_WIDTH-1:0]   next_key,
  input  wire                    seen_in,
  output logic                   seen_out,
  output logic [KEY_WIDTH-1:0]   key_out
);
  import ckset_pkg::*;

  logic [KEY_WIDTH-1:0] key;
  logic                 live;
  logic                 tail;
  logic                 match;

  assign live     = CNT_W'(IDX) < cnt;
  assign tail     = CNT_W'(IDX) == cnt;
  assign match    = live && (key == k);
  assign seen_out = seen_in | match;
  assign key_out  = key;

  // at or past the deleted slot: take the neighbor's key
  always_ff @(posedge clk) begin
    if (ctl.del_en && seen_out) begin
      key <= next_key;
    end else if (ctl.ins_en && tail) begin
      key <= k;
    end
  end

endmodule : ckset_cell
`default_nettype wire
